// ===== sv/czpe_pkg.sv =====
// Shared types, codes and arithmetic helpers of the chirp-z polynomial evaluator.
package czpe_pkg;

  localparam int ACC_W     = 98;
  localparam int RND_W     = 68;
  localparam int DIV_STEPS = 61;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_A_ZERO   = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [2:0] REG_A_REAL     = 3'd0;
  localparam logic [2:0] REG_A_IMAG     = 3'd1;
  localparam logic [2:0] REG_W_REAL     = 3'd2;
  localparam logic [2:0] REG_W_IMAG     = 3'd3;
  localparam logic [2:0] REG_NUM_POINTS = 3'd4;

  localparam logic signed [RND_W-1:0] MAX32 = 68'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [RND_W-1:0] MIN32 = 68'shF_FFFF_FFFF_8000_0000;
  localparam logic signed [RND_W-1:0] MAX64 = 68'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [RND_W-1:0] MIN64 = 68'shF_8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] coef_re;
    logic signed [31:0] coef_im;
    logic               coef_last;
  } coef_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic [5:0]         point_index;
    logic               out_last;
    logic [1:0]         status;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DEN, S_DIV_INIT, S_DIV, S_Z_INIT,
    S_POINT, S_ACC_LOAD, S_HORNER, S_EMIT, S_Z_UPD, S_DONE
  } state_t;

  typedef enum logic [1:0] {SUM_HOLD, SUM_CLEAR, SUM_COEF} sum_op_t;

  typedef enum logic [1:0] {Y_RE_HI, Y_RE_LO, Y_IM_HI, Y_IM_LO} ysel_t;

  typedef struct packed {
    logic  x_im;
    ysel_t ysel;
    logic  neg;
    logic  tgt_im;
  } mul_op_t;

  typedef struct packed {
    logic       coef_wr;
    logic       rd_en;
    sum_op_t    sum_op;
    logic       mul_vld;
    logic       mul_den;
    logic       mul_use_w;
    logic [2:0] mul_idx;
    logic       acc_load;
    logic       acc_fin;
    logic       z_fin;
    logic       den_cap;
    logic       div_init;
    logic       div_step;
    logic       z_init;
    logic       out_load;
    logic [5:0] out_index;
    logic       out_last;
    logic [1:0] out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic       a_zero;
    logic [6:0] m_eff;
  } dp_stat_t;

  // The eight partial products of one complex multiply, z split in halves.
  function automatic mul_op_t mul_op(input logic [2:0] idx);
    mul_op_t op;
    case (idx)
      3'd0: op = '{x_im: 1'b0, ysel: Y_RE_HI, neg: 1'b0, tgt_im: 1'b0};
      3'd1: op = '{x_im: 1'b0, ysel: Y_RE_LO, neg: 1'b0, tgt_im: 1'b0};
      3'd2: op = '{x_im: 1'b1, ysel: Y_IM_HI, neg: 1'b1, tgt_im: 1'b0};
      3'd3: op = '{x_im: 1'b1, ysel: Y_IM_LO, neg: 1'b1, tgt_im: 1'b0};
      3'd4: op = '{x_im: 1'b0, ysel: Y_IM_HI, neg: 1'b0, tgt_im: 1'b1};
      3'd5: op = '{x_im: 1'b0, ysel: Y_IM_LO, neg: 1'b0, tgt_im: 1'b1};
      3'd6: op = '{x_im: 1'b1, ysel: Y_RE_HI, neg: 1'b0, tgt_im: 1'b1};
      default: op = '{x_im: 1'b1, ysel: Y_RE_LO, neg: 1'b0, tgt_im: 1'b1};
    endcase
    return op;
  endfunction

  function automatic logic signed [RND_W-1:0] rnd30(input logic signed [ACC_W-1:0] t);
    logic signed [ACC_W-1:0] b;
    b = t + 98'sd536870912;
    return RND_W'(b >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RND_W-1:0] v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < MIN32) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [RND_W-1:0] v);
    logic signed [63:0] r;
    if (v > MAX64) begin
      r = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (v < MIN64) begin
      r = 64'sh8000_0000_0000_0000;
    end else begin
      r = v[63:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/czpe_datapath.sv =====
// Datapath: coefficient memory, configuration registers, multiply-accumulate, divider, output register.
module czpe_datapath import czpe_pkg::*; #(
  parameter int MAX_COEFFS = 64,
  parameter int MAX_POINTS = 64,
  localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  coef_t         coef,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  input  dp_cmd_t       cmd,
  output dp_stat_t      stat,
  output result_t       result
);

  logic signed [31:0] a_real, a_imag, w_real, w_imag;
  logic [6:0]         num_points;

  logic [63:0] store [MAX_COEFFS];
  logic [63:0] rdata;
  logic signed [31:0] rd_re, rd_im;

  logic signed [31:0] acc_re, acc_im;
  logic signed [63:0] z_re, z_im;
  logic signed [ACC_W-1:0] sum_re, sum_im;

  logic signed [32:0] mx, my;
  logic signed [65:0] p;
  logic p_vld, p_sh, p_neg, p_tgt;
  logic m_sh, m_neg, m_tgt;
  mul_op_t op;
  logic signed [ACC_W-1:0] pe, addend;

  logic [31:0] ur, ui;
  logic [63:0] den;
  logic [64:0] rem_r, rem_i, num_r, num_i, r2_r, r2_i;
  logic [61:0] q_r, q_i;
  logic ge_r, ge_i, q0_r, q0_i;
  logic [62:0] qr1, qi1;
  logic signed [63:0] rr, ri;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_real     <= 32'sh4000_0000;
      a_imag     <= '0;
      w_real     <= 32'sh4000_0000;
      w_imag     <= '0;
      num_points <= 7'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_A_REAL:     a_real     <= cfg_data;
        REG_A_IMAG:     a_imag     <= cfg_data;
        REG_W_REAL:     w_real     <= cfg_data;
        REG_W_IMAG:     w_imag     <= cfg_data;
        REG_NUM_POINTS: num_points <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.a_zero = (a_real == '0) && (a_imag == '0);
    if (num_points == 7'd0) begin
      stat.m_eff = 7'd1;
    end else if (num_points > 7'(MAX_POINTS)) begin
      stat.m_eff = 7'(MAX_POINTS);
    end else begin
      stat.m_eff = num_points;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr) begin
      store[waddr] <= {coef.coef_re, coef.coef_im};
    end
    if (cmd.rd_en) begin
      rdata <= store[raddr];
    end
  end

  assign rd_re = rdata[63:32];
  assign rd_im = rdata[31:0];

  assign ur = a_real[31] ? (~a_real + 32'd1) : a_real;
  assign ui = a_imag[31] ? (~a_imag + 32'd1) : a_imag;

  always_comb begin
    op    = mul_op(cmd.mul_idx);
    mx    = '0;
    my    = '0;
    m_sh  = 1'b0;
    m_neg = 1'b0;
    m_tgt = 1'b0;
    if (cmd.mul_den) begin
      mx = cmd.mul_idx[0] ? {1'b0, ui} : {1'b0, ur};
      my = mx;
    end else begin
      if (op.x_im) begin
        mx = cmd.mul_use_w ? 33'(w_imag) : 33'(acc_im);
      end else begin
        mx = cmd.mul_use_w ? 33'(w_real) : 33'(acc_re);
      end
      case (op.ysel)
        Y_RE_HI: my = 33'($signed(z_re[63:32]));
        Y_RE_LO: my = {1'b0, z_re[31:0]};
        Y_IM_HI: my = 33'($signed(z_im[63:32]));
        default: my = {1'b0, z_im[31:0]};
      endcase
      m_sh  = (op.ysel == Y_RE_HI) || (op.ysel == Y_IM_HI);
      m_neg = op.neg;
      m_tgt = op.tgt_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    p     <= mx * my;
    p_sh  <= m_sh;
    p_neg <= m_neg;
    p_tgt <= m_tgt;
  end

  always_comb begin
    pe     = ACC_W'(p);
    addend = p_sh ? (pe <<< 32) : pe;
    if (p_neg) begin
      addend = -addend;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.sum_op)
      SUM_CLEAR: begin
        sum_re <= '0;
        sum_im <= '0;
      end
      SUM_COEF: begin
        sum_re <= ACC_W'(rd_re) <<< 30;
        sum_im <= ACC_W'(rd_im) <<< 30;
      end
      default: begin
        if (p_vld) begin
          if (p_tgt) begin
            sum_im <= sum_im + addend;
          end else begin
            sum_re <= sum_re + addend;
          end
        end
      end
    endcase
  end

  always_comb begin
    num_r = {33'd0, ur};
    num_i = {33'd0, ui};
    q0_r  = num_r >= {1'b0, den};
    q0_i  = num_i >= {1'b0, den};
    r2_r  = {rem_r[63:0], 1'b0};
    r2_i  = {rem_i[63:0], 1'b0};
    ge_r  = r2_r >= {1'b0, den};
    ge_i  = r2_i >= {1'b0, den};
    qr1   = {1'b0, q_r} + 63'd1;
    qi1   = {1'b0, q_i} + 63'd1;
    rr    = {2'b00, qr1[62:1]};
    ri    = {2'b00, qi1[62:1]};
  end

  always_ff @(posedge clk) begin
    if (cmd.den_cap) begin
      den <= sum_re[63:0];
    end
    if (cmd.div_init) begin
      rem_r <= q0_r ? (num_r - {1'b0, den}) : num_r;
      rem_i <= q0_i ? (num_i - {1'b0, den}) : num_i;
      q_r   <= {61'd0, q0_r};
      q_i   <= {61'd0, q0_i};
    end else if (cmd.div_step) begin
      rem_r <= ge_r ? (r2_r - {1'b0, den}) : r2_r;
      rem_i <= ge_i ? (r2_i - {1'b0, den}) : r2_i;
      q_r   <= {q_r[60:0], ge_r};
      q_i   <= {q_i[60:0], ge_i};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.z_init) begin
      z_re <= a_real[31] ? -rr : rr;
      z_im <= a_imag[31] ? ri : -ri;
    end else if (cmd.z_fin) begin
      z_re <= sat64(rnd30(sum_re));
      z_im <= sat64(rnd30(sum_im));
    end
    if (cmd.acc_load) begin
      acc_re <= rd_re;
      acc_im <= rd_im;
    end else if (cmd.acc_fin) begin
      acc_re <= sat32(rnd30(sum_re));
      acc_im <= sat32(rnd30(sum_im));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.out_re      <= (cmd.out_status == STATUS_OK) ? acc_re : '0;
      result.out_im      <= (cmd.out_status == STATUS_OK) ? acc_im : '0;
      result.point_index <= cmd.out_index;
      result.out_last    <= cmd.out_last;
      result.status      <= cmd.out_status;
    end
  end

endmodule

// ===== sv/czpe_controller.sv =====
// Controller: coefficient loading, run sequencing and result handshake.
module czpe_controller import czpe_pkg::*; #(
  parameter int MAX_COEFFS = 64,
  localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1,
  localparam int CW = $clog2(MAX_COEFFS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_last,
  output logic          out_valid,
  input  logic          out_ready,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] waddr,
  output logic [AW-1:0] raddr
);

  state_t     state, state_next;
  logic [CW-1:0] count, count_next, j, j_next;
  logic       ovf, ovf_next;
  logic [3:0] phase, phase_next;
  logic [5:0] dcnt, dcnt_next;
  logic [6:0] k, k_next;
  logic [1:0] run_status, run_status_next;
  logic       out_valid_next;
  logic       is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      ovf        <= 1'b0;
      phase      <= '0;
      dcnt       <= '0;
      k          <= '0;
      j          <= '0;
      run_status <= STATUS_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      ovf        <= ovf_next;
      phase      <= phase_next;
      dcnt       <= dcnt_next;
      k          <= k_next;
      j          <= j_next;
      run_status <= run_status_next;
      out_valid  <= out_valid_next;
    end
  end

  assign waddr   = count[AW-1:0];
  assign is_last = (k + 7'd1) == stat.m_eff;

  always_comb begin
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    phase_next      = phase;
    dcnt_next       = dcnt;
    k_next          = k;
    j_next          = j;
    run_status_next = run_status;
    out_valid_next  = out_valid && !out_ready;
    in_ready        = 1'b0;
    raddr           = j[AW-1:0];
    cmd             = '0;
    cmd.sum_op      = SUM_HOLD;
    cmd.out_index   = k[5:0];
    cmd.out_last    = is_last;
    cmd.out_status  = run_status;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count < CW'(MAX_COEFFS)) begin
            cmd.coef_wr = 1'b1;
            count_next  = count + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        k_next     = '0;
        phase_next = '0;
        if (stat.a_zero) begin
          run_status_next = STATUS_A_ZERO;
          state_next      = S_EMIT;
        end else if (ovf) begin
          run_status_next = STATUS_OVERFLOW;
          state_next      = S_EMIT;
        end else begin
          run_status_next = STATUS_OK;
          state_next      = S_DEN;
        end
      end
      S_DEN: begin
        phase_next = phase + 4'd1;
        case (phase)
          4'd0: cmd.sum_op = SUM_CLEAR;
          4'd1, 4'd2: begin
            cmd.mul_vld = 1'b1;
            cmd.mul_den = 1'b1;
            cmd.mul_idx = {2'b00, phase[1]};
          end
          4'd3: ;
          default: begin
            cmd.den_cap = 1'b1;
            state_next  = S_DIV_INIT;
          end
        endcase
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_next    = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + 6'd1;
        if (dcnt == 6'(DIV_STEPS - 1)) begin
          state_next = S_Z_INIT;
        end
      end
      S_Z_INIT: begin
        cmd.z_init = 1'b1;
        state_next = S_POINT;
      end
      S_POINT: begin
        cmd.rd_en  = 1'b1;
        raddr      = '0;
        state_next = S_ACC_LOAD;
      end
      S_ACC_LOAD: begin
        cmd.acc_load = 1'b1;
        j_next       = CW'(1);
        phase_next   = '0;
        state_next   = (count > CW'(1)) ? S_HORNER : S_EMIT;
      end
      S_HORNER: begin
        phase_next = phase + 4'd1;
        case (phase)
          4'd0: cmd.rd_en = 1'b1;
          4'd1: cmd.sum_op = SUM_COEF;
          4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
            cmd.mul_vld = 1'b1;
            cmd.mul_idx = 3'(phase - 4'd2);
          end
          4'd10: ;
          default: begin
            cmd.acc_fin = 1'b1;
            j_next      = j + CW'(1);
            phase_next  = '0;
            if ((j + CW'(1)) >= count) begin
              state_next = S_EMIT;
            end
          end
        endcase
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          phase_next     = '0;
          if (is_last) begin
            state_next = S_DONE;
          end else if (run_status == STATUS_OK) begin
            state_next = S_Z_UPD;
          end else begin
            k_next = k + 7'd1;
          end
        end
      end
      S_Z_UPD: begin
        phase_next = phase + 4'd1;
        case (phase)
          4'd0: cmd.sum_op = SUM_CLEAR;
          4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8: begin
            cmd.mul_vld   = 1'b1;
            cmd.mul_use_w = 1'b1;
            cmd.mul_idx   = 3'(phase - 4'd1);
          end
          4'd9: ;
          default: begin
            cmd.z_fin  = 1'b1;
            k_next     = k + 7'd1;
            state_next = S_POINT;
          end
        endcase
      end
      S_DONE: begin
        count_next = '0;
        ovf_next   = 1'b0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== sv/chirp_z_polynomial_evaluator_top.sv =====
// Top level of the chirp-z polynomial evaluator.
//
//   channel  direction  handshake                payload
//   in       input      in_valid / in_ready      in_data (coef_t)
//   out      output     out_valid / out_ready    out_data (result_t)
//   cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A coefficient transfer is taken only while no run is active.
// A run first computes a reciprocal setup (one 33x33 multiplier, then a 61-step
// bit-serial divider), then evaluates each point with the eight partial products
// per complex multiply on the single shared multiplier. Error runs emit one result
// per cycle while the output is not stalled.
// Reset is synchronous and returns the configuration to its reset values.
// A stalled output holds the datapath before the next point's result is loaded.
module chirp_z_polynomial_evaluator_top import czpe_pkg::*; #(
  parameter int MAX_COEFFS = 64,
  parameter int MAX_POINTS = 64,
  localparam int AW = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  coef_t       in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [AW-1:0] waddr, raddr;

  assign cfg_ready = 1'b1;

  czpe_controller #(.MAX_COEFFS(MAX_COEFFS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_data.coef_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .waddr     (waddr),
    .raddr     (raddr)
  );

  czpe_datapath #(.MAX_COEFFS(MAX_COEFFS), .MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (in_data),
    .waddr     (waddr),
    .raddr     (raddr),
    .cmd       (cmd),
    .stat      (stat),
    .result    (out_data)
  );

endmodule

// ===== sv/czpe_checker.sv =====
// Port-level checker for the chirp-z polynomial evaluator and its bind statement.
module czpe_checker import czpe_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_OK) |->
      (out_data.out_re == '0) && (out_data.out_im == '0))
    else $error("error result carries a nonzero value");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.out_last |=> !in_ready)
    else $error("input taken before the run finished");

endmodule

bind chirp_z_polynomial_evaluator_top czpe_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
